// File: rtl/core/thac_pkg.sv
// shared types, coefficient tables and fixed-point helpers for the thrust cost block
`timescale 1ns / 1ps
`default_nettype none
package thac_pkg;

  localparam int NumThr    = 8;
  localparam int NumAxis   = 6;
  localparam int NumStages = 6;

  typedef logic signed [18:0] coef_t;
  typedef logic signed [23:0] q816_t;
  typedef logic signed [26:0] resid_t;
  typedef logic signed [47:0] acc_t;

  typedef enum logic [3:0] {
    RegTarget0 = 4'd0,
    RegTarget1 = 4'd1,
    RegTarget2 = 4'd2,
    RegTarget3 = 4'd3,
    RegTarget4 = 4'd4,
    RegTarget5 = 4'd5,
    RegWeight  = 4'd6,
    RegMode    = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctrl_t;

  // allocation matrix, signed Q.16
  localparam coef_t ALLOC_M [NumAxis][NumThr] = '{
    '{-19'sd2228, 19'sd2228, -19'sd2228, 19'sd2228,
      -19'sd13107, 19'sd13107, -19'sd13107, 19'sd13107},
    '{19'sd6160, 19'sd6160, -19'sd6160, -19'sd6160,
      -19'sd32768, -19'sd32768, 19'sd32768, 19'sd32768},
    '{-19'sd23462, 19'sd23462, 19'sd23462, -19'sd23462, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
    '{-19'sd61604, -19'sd61604, 19'sd61604, 19'sd61604, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
    '{-19'sd22282, 19'sd22282, -19'sd22282, 19'sd22282, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd65536, 19'sd65536, 19'sd65536, 19'sd65536}
  };

  localparam coef_t RED_M1 [NumAxis][2] = '{
    '{-19'sd2228, -19'sd13107}, '{19'sd6160, -19'sd32768}, '{-19'sd23462, 19'sd0},
    '{-19'sd61604, 19'sd0}, '{-19'sd22282, 19'sd0}, '{19'sd0, 19'sd65536}
  };

  localparam coef_t RED_M2 [NumThr][NumAxis] = '{
    '{19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd0, 19'sd91528, 19'sd0, 19'sd96377, 19'sd0},
    '{19'sd0, 19'sd0, 19'sd91528, 19'sd34859, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd0, 19'sd0, 19'sd34859, 19'sd96377, 19'sd0},
    '{19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
    '{19'sd0, -19'sd65536, 19'sd0, -19'sd6554, 19'sd0, 19'sd32768},
    '{-19'sd163840, 19'sd0, 19'sd0, 19'sd0, 19'sd16384, 19'sd32768},
    '{19'sd163840, 19'sd65536, 19'sd0, 19'sd6554, -19'sd16384, 19'sd0}
  };

  // constant times value, exact
  function automatic acc_t mulc(input coef_t c, input resid_t v);
    acc_t ce;
    acc_t ve;
    ce = 48'(c);
    ve = 48'(v);
    return ce * ve;
  endfunction

  // round half up from Q.32 to Q.16
  function automatic acc_t rnd16(input acc_t x);
    return (x + 48'sd32768) >>> 16;
  endfunction

  function automatic q816_t sat24(input acc_t x);
    if (x > 48'sd8388607) begin
      return 24'sh7fffff;
    end else if (x < -48'sd8388608) begin
      return 24'sh800000;
    end
    return x[23:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/thac_ctrl.sv
// valid bits and per-stage load enables of the pipeline
`timescale 1ns / 1ps
`default_nettype none
module thac_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 out_stall_i,
  output thac_pkg::pipe_ctrl_t      ctrl_o,
  output logic                      in_stall_o,
  output logic                      out_valid_o
);

  logic [thac_pkg::NumStages-1:0] valid_q;
  logic [thac_pkg::NumStages-1:0] valid_d;
  logic [thac_pkg::NumStages:0]   en;

  // a stage loads when empty or when its beat moves on
  always_comb begin
    en[thac_pkg::NumStages] = !out_stall_i;
    for (int k = thac_pkg::NumStages - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end else begin
      valid_d[0] = valid_q[0];
    end
    for (int k = 1; k < thac_pkg::NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.en   = en[thac_pkg::NumStages-1:0];
  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[thac_pkg::NumStages-1];

endmodule
`default_nettype wire

// File: rtl/core/thac_expand.sv
// stages 1-2: reduced-mode residual and derived thrusts, or pass-through
`timescale 1ns / 1ps
`default_nettype none
module thac_expand (
  input  wire logic                 clk_i,
  input  thac_pkg::pipe_ctrl_t      ctrl_i,
  input  wire logic                 reduced_i,
  input  thac_pkg::q816_t           target_i [thac_pkg::NumAxis],
  input  thac_pkg::q816_t           thrust_i [thac_pkg::NumThr],
  output thac_pkg::q816_t           f_o      [thac_pkg::NumThr]
);

  thac_pkg::resid_t r_q [thac_pkg::NumAxis];
  thac_pkg::resid_t r_d [thac_pkg::NumAxis];
  thac_pkg::q816_t  t_q [thac_pkg::NumThr];
  thac_pkg::q816_t  f_q [thac_pkg::NumThr];
  thac_pkg::q816_t  f_d [thac_pkg::NumThr];

  always_comb begin
    for (int i = 0; i < thac_pkg::NumAxis; i++) begin
      thac_pkg::acc_t p;
      thac_pkg::acc_t pr;
      p = thac_pkg::mulc(thac_pkg::RED_M1[i][0], 27'(thrust_i[0]))
        + thac_pkg::mulc(thac_pkg::RED_M1[i][1], 27'(thrust_i[1]));
      pr = thac_pkg::rnd16(p);
      r_d[i] = 27'(target_i[i]) - pr[26:0];
    end
  end

  always_comb begin
    for (int i = 0; i < thac_pkg::NumThr; i++) begin
      thac_pkg::acc_t acc;
      acc = '0;
      for (int j = 0; j < thac_pkg::NumAxis; j++) begin
        acc = acc + thac_pkg::mulc(thac_pkg::RED_M2[i][j], r_q[j]);
      end
      f_d[i] = reduced_i ? thac_pkg::sat24(thac_pkg::rnd16(acc)) : t_q[i];
    end
    // free values pass unchanged in reduced mode: thrust 0 from input 0, thrust 4 from input 1
    if (reduced_i) begin
      f_d[0] = t_q[0];
      f_d[4] = t_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      r_q <= r_d;
      t_q <= thrust_i;
    end
    if (ctrl_i.en[1]) begin
      f_q <= f_d;
    end
  end

  assign f_o = f_q;

endmodule
`default_nettype wire

// File: rtl/core/thac_score.sv
// stages 3-6: squares, allocation residual, weighting and final sum
`timescale 1ns / 1ps
`default_nettype none
module thac_score (
  input  wire logic                 clk_i,
  input  thac_pkg::pipe_ctrl_t      ctrl_i,
  input  wire logic [15:0]          weight_i,
  input  thac_pkg::q816_t           target_i [thac_pkg::NumAxis],
  input  thac_pkg::q816_t           f_i      [thac_pkg::NumThr],
  output logic [62:0]               fitness_o,
  output thac_pkg::q816_t           f_o      [thac_pkg::NumThr]
);

  // stage 3
  logic [46:0]       sq_q   [thac_pkg::NumThr];
  logic [46:0]       sq_d   [thac_pkg::NumThr];
  thac_pkg::acc_t    macc_q [thac_pkg::NumAxis];
  thac_pkg::acc_t    macc_d [thac_pkg::NumAxis];
  thac_pkg::q816_t   f3_q   [thac_pkg::NumThr];
  // stage 4
  logic [49:0]       s_q;
  logic [49:0]       s_d;
  thac_pkg::resid_t  e_q    [thac_pkg::NumAxis];
  thac_pkg::resid_t  e_d    [thac_pkg::NumAxis];
  thac_pkg::q816_t   f4_q   [thac_pkg::NumThr];
  // stage 5
  logic [58:0]       eff_q;
  logic [58:0]       eff_d;
  logic [51:0]       e2_q   [thac_pkg::NumAxis];
  logic [51:0]       e2_d   [thac_pkg::NumAxis];
  thac_pkg::q816_t   f5_q   [thac_pkg::NumThr];
  // stage 6
  logic [62:0]       fit_q;
  logic [62:0]       fit_d;
  thac_pkg::q816_t   f6_q   [thac_pkg::NumThr];

  always_comb begin
    for (int k = 0; k < thac_pkg::NumThr; k++) begin
      thac_pkg::acc_t fe;
      thac_pkg::acc_t sq;
      fe = 48'(f_i[k]);
      sq = fe * fe;
      sq_d[k] = sq[46:0];
    end
    for (int i = 0; i < thac_pkg::NumAxis; i++) begin
      macc_d[i] = '0;
      for (int j = 0; j < thac_pkg::NumThr; j++) begin
        macc_d[i] = macc_d[i] + thac_pkg::mulc(thac_pkg::ALLOC_M[i][j], 27'(f_i[j]));
      end
    end
  end

  always_comb begin
    s_d = '0;
    for (int k = 0; k < thac_pkg::NumThr; k++) begin
      s_d = s_d + 50'(sq_q[k]);
    end
    for (int i = 0; i < thac_pkg::NumAxis; i++) begin
      thac_pkg::acc_t mr;
      mr = thac_pkg::rnd16(macc_q[i]);
      e_d[i] = 27'(target_i[i]) - mr[26:0];
    end
  end

  always_comb begin
    logic [57:0] hi;
    logic [23:0] lo;
    // weight is Q8.8: split so the low byte rounds once
    hi = 58'(s_q[49:8]) * 58'(weight_i);
    lo = 24'(s_q[7:0]) * 24'(weight_i) + 24'd128;
    eff_d = 59'(hi) + 59'(lo[23:8]);
    for (int i = 0; i < thac_pkg::NumAxis; i++) begin
      thac_pkg::acc_t ee;
      logic signed [63:0] sq2;
      ee = 48'(e_q[i]);
      sq2 = 64'(ee) * 64'(ee);
      e2_d[i] = sq2[51:0];
    end
  end

  always_comb begin
    logic [63:0] tot;
    tot = 64'(eff_q);
    for (int i = 0; i < thac_pkg::NumAxis; i++) begin
      tot = tot + 64'(e2_q[i]);
    end
    fit_d = tot[63] ? {63{1'b1}} : tot[62:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      sq_q   <= sq_d;
      macc_q <= macc_d;
      f3_q   <= f_i;
    end
    if (ctrl_i.en[3]) begin
      s_q  <= s_d;
      e_q  <= e_d;
      f4_q <= f3_q;
    end
    if (ctrl_i.en[4]) begin
      eff_q <= eff_d;
      e2_q  <= e2_d;
      f5_q  <= f4_q;
    end
    if (ctrl_i.en[5]) begin
      fit_q <= fit_d;
      f6_q  <= f5_q;
    end
  end

  assign fitness_o = fit_q;
  assign f_o       = f6_q;

endmodule
`default_nettype wire

// File: rtl/core/thrust_allocation_cost_top.sv
// top level of the thrust allocation cost pipeline
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------
// input     | in_valid_i/in_stall_o  | thrust_0_i .. thrust_7_i (Q8.16)
// output    | out_valid_o/out_stall_i| fitness_o (Q31.32), full_thrust_0_o..7_o
// config    | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// six register stages: residual, derived thrusts, squares and allocation sums,
// thrust sum and axis error, weighting and error squares, final sum
// one beat per cycle sustained while the output is not stalled; the result comes from the final sum stage
// a stalled output holds; stages behind it fill any bubbles before input stalls
// reset clears valid bits and sets targets 0, weight 1.0, full mode
module thrust_allocation_cost_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [23:0] thrust_0_i,
  input  wire logic [23:0] thrust_1_i,
  input  wire logic [23:0] thrust_2_i,
  input  wire logic [23:0] thrust_3_i,
  input  wire logic [23:0] thrust_4_i,
  input  wire logic [23:0] thrust_5_i,
  input  wire logic [23:0] thrust_6_i,
  input  wire logic [23:0] thrust_7_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [62:0]      fitness_o,
  output logic [23:0]      full_thrust_0_o,
  output logic [23:0]      full_thrust_1_o,
  output logic [23:0]      full_thrust_2_o,
  output logic [23:0]      full_thrust_3_o,
  output logic [23:0]      full_thrust_4_o,
  output logic [23:0]      full_thrust_5_o,
  output logic [23:0]      full_thrust_6_o,
  output logic [23:0]      full_thrust_7_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  thac_pkg::q816_t      target_q [thac_pkg::NumAxis];
  logic [15:0]          weight_q;
  logic                 reduced_q;
  thac_pkg::pipe_ctrl_t ctrl;
  thac_pkg::q816_t      thrust   [thac_pkg::NumThr];
  thac_pkg::q816_t      f_mid    [thac_pkg::NumThr];
  thac_pkg::q816_t      f_out    [thac_pkg::NumThr];

  // registers always take a write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < thac_pkg::NumAxis; i++) begin
        target_q[i] <= '0;
      end
      weight_q  <= 16'd256;
      reduced_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        thac_pkg::RegTarget0: target_q[0] <= cfg_data_i;
        thac_pkg::RegTarget1: target_q[1] <= cfg_data_i;
        thac_pkg::RegTarget2: target_q[2] <= cfg_data_i;
        thac_pkg::RegTarget3: target_q[3] <= cfg_data_i;
        thac_pkg::RegTarget4: target_q[4] <= cfg_data_i;
        thac_pkg::RegTarget5: target_q[5] <= cfg_data_i;
        thac_pkg::RegWeight:  weight_q    <= cfg_data_i[15:0];
        thac_pkg::RegMode:    reduced_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign thrust[0] = thrust_0_i;
  assign thrust[1] = thrust_1_i;
  assign thrust[2] = thrust_2_i;
  assign thrust[3] = thrust_3_i;
  assign thrust[4] = thrust_4_i;
  assign thrust[5] = thrust_5_i;
  assign thrust[6] = thrust_6_i;
  assign thrust[7] = thrust_7_i;

  thac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // stages 1-2
  thac_expand u_expand (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .reduced_i (reduced_q),
    .target_i  (target_q),
    .thrust_i  (thrust),
    .f_o       (f_mid)
  );

  // stages 3-6
  thac_score u_score (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .weight_i  (weight_q),
    .target_i  (target_q),
    .f_i       (f_mid),
    .fitness_o (fitness_o),
    .f_o       (f_out)
  );

  assign full_thrust_0_o = f_out[0];
  assign full_thrust_1_o = f_out[1];
  assign full_thrust_2_o = f_out[2];
  assign full_thrust_3_o = f_out[3];
  assign full_thrust_4_o = f_out[4];
  assign full_thrust_5_o = f_out[5];
  assign full_thrust_6_o = f_out[6];
  assign full_thrust_7_o = f_out[7];

endmodule
`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for the thrust allocation cost pipeline
`timescale 1ns / 1ps
module tb;

  // cost beat: fitness and expanded thrusts
  typedef struct {
    logic [62:0] fit;
    logic [23:0] thr [8];
  } cost_beat_t;

  // one directed row: thrusts, and a typed-in fitness where obvious
  typedef struct {
    logic [23:0] thr [8];
    bit          has_fit;
    logic [62:0] fit;
  } dir_row_t;

  localparam longint Q63MAX = 64'h7fffffffffffffff;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [23:0] thrust_i [8];
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [62:0] fitness_o;
  logic [23:0] full_thrust_o [8];
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  // predictor copy of the registers
  longint      tgt_m [6];
  longint      weight_m;
  bit          reduced_m;

  cost_beat_t  cost_q [$];
  int          n_err = 0;
  int          stall_left = 0;
  bit          out_idle_en = 1'b1;
  bit          in_idle_en = 1'b1;

  initial for (int i = 0; i < 8; i++) thrust_i[i] = '0;

  always #5 clk_i = ~clk_i;

  thrust_allocation_cost_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .thrust_0_i(thrust_i[0]), .thrust_1_i(thrust_i[1]), .thrust_2_i(thrust_i[2]),
    .thrust_3_i(thrust_i[3]), .thrust_4_i(thrust_i[4]), .thrust_5_i(thrust_i[5]),
    .thrust_6_i(thrust_i[6]), .thrust_7_i(thrust_i[7]),
    .out_valid_o, .out_stall_i, .fitness_o,
    .full_thrust_0_o(full_thrust_o[0]), .full_thrust_1_o(full_thrust_o[1]),
    .full_thrust_2_o(full_thrust_o[2]), .full_thrust_3_o(full_thrust_o[3]),
    .full_thrust_4_o(full_thrust_o[4]), .full_thrust_5_o(full_thrust_o[5]),
    .full_thrust_6_o(full_thrust_o[6]), .full_thrust_7_o(full_thrust_o[7]),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // round half toward plus infinity from Q.32 to Q.16
  function automatic longint q16_round(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp24(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  // score one candidate against the current targets
  function automatic cost_beat_t score_candidate(logic [23:0] cand [8]);
    longint     f [8];
    longint     r [6];
    longint     acc;
    longint     e;
    logic [63:0] s;
    logic [63:0] eff;
    logic [63:0] res;
    logic [63:0] tot;
    cost_beat_t b;
    s = 0;
    res = 0;
    for (int i = 0; i < 8; i++) f[i] = longint'($signed(cand[i]));
    if (reduced_m) begin
      for (int i = 0; i < 6; i++)
        r[i] = tgt_m[i] - q16_round(longint'(thac_pkg::RED_M1[i][0]) * f[0]
                                    + longint'(thac_pkg::RED_M1[i][1]) * f[1]);
      for (int i = 0; i < 8; i++) begin
        if (i != 0 && i != 4) begin
          acc = 0;
          for (int j = 0; j < 6; j++) acc += longint'(thac_pkg::RED_M2[i][j]) * r[j];
          f[i] = clamp24(q16_round(acc));
        end
      end
      // thrust 4 carries the second free value
      f[4] = longint'($signed(cand[1]));
    end
    for (int i = 0; i < 8; i++) s += 64'(f[i] * f[i]);
    eff = (s >> 8) * weight_m + (((s & 64'hff) * weight_m + 64'd128) >> 8);
    for (int i = 0; i < 6; i++) begin
      acc = 0;
      for (int j = 0; j < 8; j++) acc += longint'(thac_pkg::ALLOC_M[i][j]) * f[j];
      e = tgt_m[i] - q16_round(acc);
      res += 64'(e * e);
    end
    tot = eff + res;
    if (tot < eff || tot > 64'(Q63MAX)) tot = 64'(Q63MAX);
    b.fit = tot[62:0];
    for (int i = 0; i < 8; i++) b.thr[i] = f[i][23:0];
    return b;
  endfunction

  // valid stays high until the next send_candidate drops it
  task automatic write_reg(thac_pkg::reg_idx_e idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      thac_pkg::RegWeight: weight_m  = val[15:0];
      thac_pkg::RegMode:   reduced_m = val[0];
      default:             tgt_m[idx] = longint'($signed(val));
    endcase
  endtask

  // random burst of idle cycles, or none
  task automatic idle_burst(bit en);
    if (en && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk_i);
    end
  endtask

  // send one candidate, expectation computed at acceptance
  task automatic send_candidate(logic [23:0] cand [8]);
    cfg_valid_i <= 1'b0;
    idle_burst(in_idle_en);
    in_valid_i <= 1'b1;
    for (int i = 0; i < 8; i++) thrust_i[i] <= cand[i];
    do @(posedge clk_i); while (in_stall_o);
    cost_q.push_back(score_candidate(cand));
  endtask

  // drain the pipe, then allow the six stages to empty out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_thrust();
    case ($urandom_range(5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(2048)) - 1024);
      default: return 24'($urandom);
    endcase
  endfunction

  // output side: random stall bursts, compare at each accepted beat
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (cost_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected cost beat fit=%h", fitness_o);
        end else begin
          cost_beat_t x;
          bit bad;
          x = cost_q.pop_front();
          bad = (x.fit !== fitness_o);
          for (int i = 0; i < 8; i++) if (x.thr[i] !== full_thrust_o[i]) bad = 1'b1;
          if (bad) begin
            n_err++;
            if (n_err <= 10) begin
              $display("mismatch fit exp=%h act=%h", x.fit, fitness_o);
              for (int i = 0; i < 8; i++)
                $display("  thrust %0d exp=%h act=%h", i, x.thr[i], full_thrust_o[i]);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end else if (out_idle_en && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(10, 1);
        out_stall_i <= 1'b1;
      end
    end
  end

  // directed table: zero, extremes, ignored inputs in reduced mode
  dir_row_t dir_tbl [$];

  task automatic add_row(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                         bit hf, logic [62:0] fv);
    dir_row_t row;
    row.thr[0] = a;
    row.thr[1] = b;
    for (int i = 2; i < 8; i++) row.thr[i] = c;
    row.has_fit = hf;
    row.fit = fv;
    dir_tbl.push_back(row);
  endtask

  task automatic run_table();
    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].has_fit) begin
        cost_beat_t b;
        b = score_candidate(dir_tbl[k].thr);
        if (b.fit !== dir_tbl[k].fit) begin
          n_err++;
          if (n_err <= 10) $display("table row %0d fit exp=%h pred=%h", k,
                                    dir_tbl[k].fit, b.fit);
        end
      end
      send_candidate(dir_tbl[k].thr);
    end
    dir_tbl.delete();
  endtask

  initial begin
    logic [23:0] cand [8];
    for (int i = 0; i < 6; i++) tgt_m[i] = 0;
    weight_m  = 256;
    reduced_m = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: zero input costs nothing
    add_row('0, '0, '0, 1'b1, '0);
    add_row(24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0, '0);
    add_row(24'h800000, 24'h800000, 24'h800000, 1'b0, '0);
    add_row(24'h800000, 24'h7fffff, 24'h555555, 1'b0, '0);
    add_row(24'h010000, '0, '0, 1'b0, '0);
    add_row(24'hffffff, 24'h000001, 24'haaaaaa, 1'b0, '0);
    run_table();
    wait_idle();

    // weight zero and full, extreme targets
    write_reg(thac_pkg::RegWeight, 24'h0);
    for (int i = 0; i < 6; i++) write_reg(thac_pkg::reg_idx_e'(i), 24'h7fffff);
    add_row('0, '0, '0, 1'b0, '0);
    add_row(24'h7fffff, 24'h800000, 24'h7fffff, 1'b0, '0);
    run_table();
    wait_idle();
    write_reg(thac_pkg::RegWeight, 24'hffff);
    for (int i = 0; i < 6; i++) write_reg(thac_pkg::reg_idx_e'(i), 24'h800000);
    add_row(24'h7fffff, 24'h7fffff, 24'h800000, 1'b0, '0);
    add_row(24'h800000, 24'h800000, 24'h7fffff, 1'b0, '0);
    run_table();
    wait_idle();

    // reduced mode: thrusts 2..7 must not matter, derived values saturate
    write_reg(thac_pkg::RegMode, 24'h1);
    add_row(24'h7fffff, 24'h800000, '0, 1'b0, '0);
    add_row(24'h7fffff, 24'h800000, 24'hffffff, 1'b0, '0);
    add_row(24'h800000, 24'h7fffff, 24'h123456, 1'b0, '0);
    add_row('0, '0, 24'h7fffff, 1'b0, '0);
    run_table();
    wait_idle();

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < 6; i++)
        write_reg(thac_pkg::reg_idx_e'(i), ($urandom_range(2) == 0) ? 24'($urandom)
                                  : 24'($signed($urandom_range(1 << 19)) - (1 << 18)));
      write_reg(thac_pkg::RegWeight, (ph == 3) ? 24'h0 : (ph == 4) ? 24'hffff
                                     : 24'($urandom_range(16'hffff)));
      write_reg(thac_pkg::RegMode, 24'(ph % 2));
      if (ph == 9) begin
        // last stretch runs back to back on both sides
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
      end
      repeat (93) begin
        for (int i = 0; i < 8; i++) cand[i] = rand_thrust();
        send_candidate(cand);
      end
      wait_idle();
    end

    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: thrust_allocation_cost_top.f
rtl/core/thac_pkg.sv
rtl/core/thac_ctrl.sv
rtl/core/thac_expand.sv
rtl/core/thac_score.sv
rtl/core/thrust_allocation_cost_top.sv
dv/tb.sv
